// ----- sv/fmre_pkg.sv -----
package fmre_pkg;
  localparam int MAX_SETS = 16;
  localparam int IDX_W = $clog2(MAX_SETS);
  localparam int ONE_Q = 32768;

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_RULE = 2'd1,
    KIND_EVAL = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // queued evaluation request
  typedef struct packed {
    logic [15:0] va;
    logic [15:0] vb;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_RD, ST_SETUP, ST_DIV, ST_COMB, ST_NEXTH,
    ST_RULE, ST_RULEW, ST_EMIT
  } state_t;
endpackage

// ----- sv/fmre_ram.sv -----
module fmre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/fmre_front.sv -----
module fmre_front import fmre_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [1:0]                kind,
  input  logic [15:0]               va,
  input  logic [15:0]               vb,
  input  logic [3:0]                row,
  input  logic [3:0]                col,
  input  logic [53:0]               pts,
  input  logic [3:0]                rule,
  output logic                      set_we,
  output logic [IDX_W-1:0]          set_wa,
  output logic [53:0]               set_wd,
  output logic                      rule_we,
  output logic [2*IDX_W-1:0]        rule_wa,
  output logic [3:0]                rule_wd,
  output logic                      q_valid,
  output job_t                      q_data,
  input  logic                      q_pop,
  input  logic                      be_busy
);
  // two-entry queue of evaluation jobs
  job_t       q_mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       load_kind;

  // a load waits until every earlier evaluation has finished with the tables
  assign load_kind = (kind == KIND_SET) || (kind == KIND_RULE);
  assign in_tready = (cnt_r != 2'd2) && !(load_kind && ((cnt_r != 2'd0) || be_busy));
  assign push = in_tvalid && in_tready && (kind == KIND_EVAL);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_mem_r[rp_r];

  assign set_we = in_tvalid && in_tready && (kind == KIND_SET) && ({1'b0, row} < 5'(MAX_SETS));
  assign set_wa = row[IDX_W-1:0];
  assign set_wd = pts;
  assign rule_we = in_tvalid && in_tready && (kind == KIND_RULE)
                   && ({1'b0, row} < 5'(MAX_SETS)) && ({1'b0, col} < 5'(MAX_SETS));
  assign rule_wa = {row[IDX_W-1:0], col[IDX_W-1:0]};
  assign rule_wd = rule;

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= '{va: va, vb: vb};
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// ----- sv/fmre_div.sv -----
module fmre_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [17:0] num,
  input  logic [17:0] den,
  output logic        done,
  output logic [17:0] quo
);
  // restoring divide of (num*32768 + den/2) by den, one bit a cycle
  logic [34:0] rem_r, rem_nxt;
  logic [33:0] dvd_r, dvd_nxt;
  logic [17:0] den_r;
  logic [33:0] q_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [35:0] trial;

  assign trial = {rem_r, dvd_r[33]} - {18'd0, den_r};
  always_comb begin
    rem_nxt = {rem_r[33:0], dvd_r[33]};
    if (!trial[35]) rem_nxt = trial[34:0];
    dvd_nxt = {dvd_r[32:0], 1'b0};
  end
  assign done = busy_r && (cnt_r == 6'd0);
  assign quo = (q_r > 34'd65536) ? 18'd65536 : q_r[17:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd34;
      rem_r <= '0;
      dvd_r <= {1'b0, num, 15'd0} + {17'd0, den[17:1]};
      den_r <= den;
      q_r <= '0;
    end else if (busy_r && cnt_r != 6'd0) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      q_r <= {q_r[32:0], ~trial[35]};
      cnt_r <= cnt_r - 6'd1;
    end else begin
      busy_r <= 1'b0;
    end
  end
endmodule

// ----- sv/fmre_back.sv -----
module fmre_back import fmre_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [4:0]         nsets,
  input  logic               q_valid,
  input  job_t               q_data,
  output logic               q_pop,
  output logic               busy,
  output logic [IDX_W-1:0]   set_ra,
  input  logic [53:0]        set_rd,
  output logic [2*IDX_W-1:0] rule_ra,
  input  logic [3:0]         rule_rd,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [3:0]         o_set,
  output logic [15:0]        o_str,
  output logic               o_last,
  output logic               o_empty,
  output logic               o_ovf
);
  state_t state_r, state_nxt;
  job_t   job_r;
  logic [4:0]       i_r;         // scan index
  logic             side_r;      // 0 input a, 1 input b
  logic [IDX_W-1:0] ia_r [2], ib_r [2];
  logic [1:0]       na_r, nb_r;
  logic             ovf_r;
  logic [16:0]      ha_r [2], hb_r [2];
  logic             hk_r;        // which match being heighted
  logic             part_r;      // which fraction of a triangle
  logic [17:0]      h1_r;        // first height of a middle set
  logic             pi_r, pj_r;
  logic             dstart, ddone;
  logic [17:0]      dnum, dden, dquo;
  logic signed [18:0] num_s, den_s;
  logic             neg_r;
  logic signed [18:0] fr_r;
  logic             v_r;

  logic signed [16:0] pl, pp, pr;
  logic signed [17:0] vs;
  logic [15:0] vcur;
  logic [1:0]  ncur;
  logic [IDX_W-1:0] icur;
  logic is_first, is_last_set;

  assign pl = set_rd[16:0];
  assign pp = set_rd[33:17];
  assign pr = set_rd[50:34];
  assign vcur = side_r ? job_r.vb : job_r.va;
  assign vs = {2'b00, vcur};
  assign ncur = side_r ? nb_r : na_r;
  assign icur = side_r ? ib_r[hk_r] : ia_r[hk_r];
  assign is_first = (icur == '0);
  assign is_last_set = ({1'b0, icur} == 5'(nsets - 5'd1));

  // registered read: the address goes out one state ahead of its use;
  // during the scan, set a0 is fetched for the first height setup
  always_comb begin
    if (state_r == ST_RD) set_ra = i_r[IDX_W-1:0];
    else if (state_r == ST_SCAN) set_ra = ia_r[0];
    else set_ra = icur;
  end
  assign rule_ra = {ia_r[pi_r], ib_r[pj_r]};

  // fraction operands: part 0 is (v-P)/(R-P) except last set; part 1 is (P-v)/(P-L)
  always_comb begin
    num_s = 19'(vs) - 19'(pp);
    den_s = 19'(pr) - 19'(pp);
    if (is_last_set && !is_first) begin
      num_s = 19'(vs) - 19'(pl);
      den_s = 19'(pp) - 19'(pl);
    end else if (part_r) begin
      num_s = 19'(pp) - 19'(vs);
      den_s = 19'(pp) - 19'(pl);
    end
    dnum = num_s[18] ? 18'(-num_s) : num_s[17:0];
    dden = den_s[18] ? 18'(-den_s) : den_s[17:0];
  end

  fmre_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
                  .done(ddone), .quo(dquo));

  logic signed [19:0] hcalc;
  logic signed [19:0] hsat_in;
  logic [17:0] hsat;
  always_comb begin
    if (is_last_set && !is_first) hcalc = 20'(fr_r);
    else hcalc = 20'sd32768 - 20'(fr_r);
    hsat_in = hcalc;
    if (!is_first && !(is_last_set) && part_r && $signed({2'b0, h1_r}) < hsat_in)
      hsat_in = $signed({2'b0, h1_r});
    if (hsat_in < 0) hsat = 18'd0;
    else if (hsat_in > 20'sd32768) hsat = 18'd32768;
    else hsat = hsat_in[17:0];
  end

  logic match_hit;
  assign match_hit = ($signed(vs) > $signed({pl[16], pl})) &&
                     ($signed(vs) < $signed({pr[16], pr}));

  logic [16:0] sa, sb;
  assign sa = ha_r[pi_r];
  assign sb = hb_r[pj_r];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (i_r == nsets - 5'd1) begin
          if (side_r) begin
            if (na_r == 2'd0 || (nb_r == 2'd0 && !match_hit)) state_nxt = ST_EMIT;
            else state_nxt = ST_SETUP;
          end else state_nxt = ST_RD;
        end else state_nxt = ST_RD;
      end
      // zero denominator needs no divide
      ST_SETUP: state_nxt = (dden == 18'd0) ? ST_COMB : ST_DIV;
      ST_DIV:   if (ddone) state_nxt = ST_COMB;
      ST_COMB:  state_nxt = ST_NEXTH;
      ST_NEXTH: state_nxt = v_r ? ST_RULE : ST_SETUP;
      ST_RULE:  state_nxt = ST_RULEW;
      ST_RULEW: state_nxt = ST_EMIT;
      ST_EMIT:  if (!out_tvalid || out_tready) state_nxt = o_last ? ST_IDLE : ST_RULE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign q_pop = (state_r == ST_IDLE) && q_valid;
  assign busy = (state_r != ST_IDLE);
  assign dstart = (state_r == ST_SETUP) && (dden != 18'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_tvalid <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: if (q_valid) begin
          job_r <= q_data; i_r <= 5'd0; side_r <= 1'b0; ovf_r <= 1'b0;
          if (q_data.va == 16'd0) begin
            ia_r[0] <= '0; na_r <= 2'd1;
          end else if (q_data.va == 16'(ONE_Q)) begin
            ia_r[0] <= IDX_W'(nsets - 5'd1); na_r <= 2'd1;
          end else na_r <= 2'd0;
          if (q_data.vb == 16'd0) begin
            ib_r[0] <= '0; nb_r <= 2'd1;
          end else if (q_data.vb == 16'(ONE_Q)) begin
            ib_r[0] <= IDX_W'(nsets - 5'd1); nb_r <= 2'd1;
          end else nb_r <= 2'd0;
        end
        ST_RD: ;
        ST_SCAN: begin
          if (match_hit) begin
            if (ncur == 2'd2) ovf_r <= 1'b1;
            else if (side_r) begin
              ib_r[nb_r[0]] <= i_r[IDX_W-1:0]; nb_r <= nb_r + 2'd1;
            end else begin
              ia_r[na_r[0]] <= i_r[IDX_W-1:0]; na_r <= na_r + 2'd1;
            end
          end
          if (i_r == nsets - 5'd1) begin
            i_r <= 5'd0;
            side_r <= ~side_r;
            if (side_r) begin
              hk_r <= 1'b0; part_r <= 1'b0;
            end
          end else i_r <= i_r + 5'd1;
          if (state_nxt == ST_EMIT) begin
            out_tvalid <= 1'b1; o_set <= 4'd0; o_str <= 16'd0; o_last <= 1'b1;
            o_empty <= 1'b1;
            o_ovf <= ovf_r || (match_hit && ncur == 2'd2);
          end
        end
        ST_SETUP: begin
          neg_r <= num_s[18] != den_s[18];
          if (dden == 18'd0)
            fr_r <= (num_s == 0) ? 19'sd0 : (num_s[18] ? -19'sd65536 : 19'sd65536);
        end
        ST_DIV: if (ddone) fr_r <= neg_r ? -$signed({1'b0, dquo}) : $signed({1'b0, dquo});
        ST_COMB: begin
          if (!is_first && !is_last_set && !part_r) begin
            h1_r <= 18'(hcalc < 0 ? 20'sd0 : hcalc);
            part_r <= 1'b1;
            v_r <= 1'b0;
          end else begin
            part_r <= 1'b0;
            if (side_r) hb_r[hk_r] <= hsat[16:0];
            else ha_r[hk_r] <= hsat[16:0];
            if ({1'b0, hk_r} + 2'd1 < ncur) begin
              hk_r <= 1'b1; v_r <= 1'b0;
            end else if (!side_r) begin
              side_r <= 1'b1; hk_r <= 1'b0; v_r <= 1'b0;
            end else begin
              v_r <= 1'b1; pi_r <= 1'b0; pj_r <= 1'b0;
            end
          end
        end
        ST_NEXTH: ;
        ST_RULE: ;
        ST_RULEW: begin
          out_tvalid <= 1'b1;
          o_set <= rule_rd;
          o_str <= (sa < sb) ? sa[15:0] : sb[15:0];
          o_last <= ({1'b0, pi_r} == na_r - 2'd1) && ({1'b0, pj_r} == nb_r - 2'd1);
          o_empty <= 1'b0;
          o_ovf <= ovf_r;
        end
        ST_EMIT: if ((!out_tvalid || out_tready) && !o_last) begin
          if ({1'b0, pj_r} + 2'd1 < nb_r) pj_r <= 1'b1;
          else begin pj_r <= 1'b0; pi_r <= 1'b1; end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/fuzzy_min_rule_evaluator.sv -----
// Fuzzy min-rule evaluator, two inputs, triangular sets.
// in_ channel: kind 0 loads set breakpoints, kind 1 a rule entry, kind 2
// evaluates a pair, kind 3 is dropped. A load waits until no evaluation is
// queued or running, then is written to its table and produces nothing.
// Evaluations go into a two-entry job queue.
// out_ channel: one to four transfers per evaluation, last marked by tlast;
// a no-match evaluation gives one transfer with the empty flag.
// Steps: a scan of 2*sets_in_use reads, then per fraction (up to eight) a
// setup, a divide in the shared serial divider and a combine (a zero
// denominator skips the divide), then a rule read and a transfer per result.
// The back end works on one evaluation at a time; the front end queues
// further jobs meanwhile.
// Output is held in a register; while the receiver stalls the back end
// waits and the front end keeps taking up to two jobs; loads wait.
// Reset (synchronous, rst_n low) empties the queue, idles the back end and
// sets sets_in_use to 16. Set and rule tables are undefined until loaded.
// cfg_wdata is saturated to [2, 16] on write.
module fuzzy_min_rule_evaluator import fmre_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // value_a[15:0] value_b[31:16] table_row[35:32] table_col[39:36]
  // point_left[56:40] point_peak[73:57] point_right[90:74] rule_out[94:91]
  input  logic [95:0]  in_tdata,
  input  logic [1:0]   in_tuser,   // kind[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // out_set[3:0] strength[19:4]
  output logic         out_tlast,
  output logic [1:0]   out_tuser,  // empty_res[0] overflow[1]
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata
);
  logic [4:0] nsets_r;
  always_ff @(posedge clk) begin
    if (!rst_n) nsets_r <= 5'd16;
    else if (cfg_we)
      nsets_r <= (cfg_wdata < 5'd2) ? 5'd2 :
                 (cfg_wdata > 5'(MAX_SETS)) ? 5'(MAX_SETS) : cfg_wdata;
  end

  logic set_we, rule_we, q_valid, q_pop, be_busy;
  logic [IDX_W-1:0] set_wa, set_ra;
  logic [53:0] set_wd, set_rd;
  logic [2*IDX_W-1:0] rule_wa, rule_ra;
  logic [3:0] rule_wd, rule_rd, o_set;
  logic [15:0] o_str;
  job_t q_data;

  fmre_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .kind(in_tuser),
    .va(in_tdata[15:0]), .vb(in_tdata[31:16]), .row(in_tdata[35:32]),
    .col(in_tdata[39:36]), .pts({3'd0, in_tdata[90:40]}), .rule(in_tdata[94:91]),
    .set_we, .set_wa, .set_wd, .rule_we, .rule_wa, .rule_wd,
    .q_valid, .q_data, .q_pop, .be_busy
  );

  fmre_ram #(.WIDTH(54), .DEPTH(MAX_SETS)) u_sets (
    .clk, .we(set_we), .waddr(set_wa), .wdata(set_wd), .raddr(set_ra), .rdata(set_rd));
  fmre_ram #(.WIDTH(4), .DEPTH(MAX_SETS*MAX_SETS)) u_rules (
    .clk, .we(rule_we), .waddr(rule_wa), .wdata(rule_wd), .raddr(rule_ra), .rdata(rule_rd));

  fmre_back u_back (
    .clk, .rst_n, .nsets(nsets_r), .q_valid, .q_data, .q_pop, .busy(be_busy),
    .set_ra, .set_rd, .rule_ra, .rule_rd, .out_tvalid, .out_tready,
    .o_set, .o_str, .o_last(out_tlast), .o_empty(out_tuser[0]), .o_ovf(out_tuser[1])
  );

  assign out_tdata = {4'd0, o_str, o_set};

`ifndef SYNTH
  a_nsets_range: assert property (@(posedge clk) disable iff (!rst_n)
    nsets_r >= 5'd2 && nsets_r <= 5'(MAX_SETS)) else $error("sets_in_use out of range");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == 24'd0)
    else $error("empty result not cleared");
  a_str_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[19:4] <= 16'd32768) else $error("strength above one");
`endif
endmodule
